### hw/rtl/spwm_pkg.sv
// shared types and constants of the servo pwm generator
`timescale 1ns / 1ps

package spwm_pkg;

    localparam int CHANNELS_DEF = 6;
    localparam int CHAN_W       = 4;
    localparam int COUNT_W      = 16;
    localparam int PWM_W        = 6;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int IN_DATA_W    = 24;
    localparam int OUT_DATA_W   = 8;

    localparam logic [COUNT_W-1:0] PRESCALE_RESET = 16'd41;
    localparam logic [COUNT_W-1:0] PERIOD_RESET   = 16'd40000;

    typedef enum logic [1:0] {
        KIND_TICK        = 2'd0,
        KIND_SET_WIDTH   = 2'd1,
        KIND_SET_ENABLE  = 2'd2,
        KIND_DISABLE_ALL = 2'd3
    } t_kind;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PRESCALE = 2'd0,
        CFG_PERIOD   = 2'd1
    } t_cfg_index;

    typedef struct packed {
        logic [COUNT_W-1:0] next_count;
        logic               wrap;
    } t_timer_step;

endpackage

### hw/rtl/servo_pwm_generator.sv
// top level of the multi-channel servo pwm generator
//
// channel   direction  handshake                      payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tuser kind, tdata set fields
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata pwm levels and flags
// cfg       in         i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// one request per cycle while s_axis_tready is high; each request yields one result,
// computed in a single pass from the input through the counter and compare logic
// a two-entry output stage (result register plus skid) lets requests flow while
// one result waits; s_axis_tready drops only when both entries are full
// synchronous active-low reset clears counters, channel state and the output stage
`timescale 1ns / 1ps

module servo_pwm_generator #(
    parameter int CHANNELS = spwm_pkg::CHANNELS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // channel[3:0], on_time[19:4], enable[20], estop[21], zero[23:22]
    input  logic [spwm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // pwm_out[5:0], period_wrap[6], refused[7]
    output logic [spwm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [spwm_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [spwm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam logic [spwm_pkg::CHAN_W:0] CHAN_LIMIT = (spwm_pkg::CHAN_W + 1)'(CHANNELS);

    logic [spwm_pkg::COUNT_W-1:0] r_prescale_div;
    logic [spwm_pkg::COUNT_W-1:0] r_period_top;

    logic [spwm_pkg::COUNT_W-1:0] r_width  [CHANNELS];
    logic [spwm_pkg::COUNT_W-1:0] n_width  [CHANNELS];
    logic [spwm_pkg::COUNT_W-1:0] r_active [CHANNELS];
    logic [spwm_pkg::COUNT_W-1:0] n_active [CHANNELS];
    logic [CHANNELS-1:0]          r_on;
    logic [CHANNELS-1:0]          n_on;
    logic [CHANNELS-1:0]          lvl;

    logic                             accept;
    spwm_pkg::t_kind                  kind;
    logic [spwm_pkg::CHAN_W-1:0]      chan;
    logic [spwm_pkg::COUNT_W-1:0]     on_time;
    logic                             en;
    logic                             estop;
    logic                             chan_ok;
    logic                             is_tick;
    logic                             refused;
    logic [spwm_pkg::PWM_W-1:0]       pwm;
    spwm_pkg::t_timer_step            step;
    logic [spwm_pkg::OUT_DATA_W-1:0]  result;

    logic                             r_out_valid;
    logic                             n_out_valid;
    logic [spwm_pkg::OUT_DATA_W-1:0]  r_out_data;
    logic [spwm_pkg::OUT_DATA_W-1:0]  n_out_data;
    logic                             r_skid_valid;
    logic                             n_skid_valid;
    logic [spwm_pkg::OUT_DATA_W-1:0]  r_skid_data;
    logic [spwm_pkg::OUT_DATA_W-1:0]  n_skid_data;
    logic                             pop;

    assign s_axis_tready = !r_skid_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign kind          = spwm_pkg::t_kind'(s_axis_tuser);
    assign chan          = s_axis_tdata[3:0];
    assign on_time       = s_axis_tdata[19:4];
    assign en            = s_axis_tdata[20];
    assign estop         = s_axis_tdata[21];
    assign chan_ok       = {1'b0, chan} < CHAN_LIMIT;
    assign is_tick       = accept && (kind == spwm_pkg::KIND_TICK);
    assign o_cfg_ready   = 1'b1;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale_div <= spwm_pkg::PRESCALE_RESET;
            r_period_top   <= spwm_pkg::PERIOD_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                spwm_pkg::CFG_PRESCALE: r_prescale_div <= i_cfg_data;
                spwm_pkg::CFG_PERIOD:   r_period_top   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    spwm_timer u_timer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tick         (is_tick),
        .i_prescale_div (r_prescale_div),
        .i_period_top   (r_period_top),
        .o_step         (step)
    );

    always_comb begin
        case (kind)
            spwm_pkg::KIND_SET_WIDTH:  refused = !chan_ok;
            spwm_pkg::KIND_SET_ENABLE: refused = !chan_ok || (estop && en);
            default:                   refused = 1'b0;
        endcase
    end

    // per-channel next state and level after the request
    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            n_width[i]  = r_width[i];
            n_on[i]     = r_on[i];
            n_active[i] = r_active[i];
            if (accept) begin
                case (kind)
                    spwm_pkg::KIND_TICK: begin
                        if (step.wrap) begin
                            n_active[i] = r_on[i] ? r_width[i] : '0;
                        end
                    end
                    spwm_pkg::KIND_SET_WIDTH: begin
                        if (chan == spwm_pkg::CHAN_W'(i)) begin
                            n_width[i] = on_time;
                        end
                    end
                    spwm_pkg::KIND_SET_ENABLE: begin
                        if (!refused && chan == spwm_pkg::CHAN_W'(i)) begin
                            n_on[i] = en;
                        end
                    end
                    spwm_pkg::KIND_DISABLE_ALL: n_on[i] = 1'b0;
                    default: ;
                endcase
            end
            lvl[i] = step.next_count < n_active[i];
        end
    end

    always_comb begin
        pwm = '0;
        for (int b = 0; b < spwm_pkg::PWM_W; b++) begin
            if (b < CHANNELS) begin
                pwm[b] = lvl[b];
            end
        end
    end

    assign result = {refused, step.wrap, pwm};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_width[i]  <= '0;
                r_active[i] <= '0;
            end
        end else begin
            r_on <= n_on;
            for (int i = 0; i < CHANNELS; i++) begin
                r_width[i]  <= n_width[i];
                r_active[i] <= n_active[i];
            end
        end
    end

    // result register with skid entry
    assign pop = r_out_valid && m_axis_tready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = accept;
                n_out_data  = result;
            end
        end else if (accept) begin
            n_skid_valid = 1'b1;
            n_skid_data  = result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

### hw/rtl/spwm_timer.sv
// prescaler and period counter of the servo pwm generator
`timescale 1ns / 1ps

module spwm_timer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_tick,
    input  logic [spwm_pkg::COUNT_W-1:0]    i_prescale_div,
    input  logic [spwm_pkg::COUNT_W-1:0]    i_period_top,
    output spwm_pkg::t_timer_step           o_step
);

    logic [spwm_pkg::COUNT_W-1:0] r_prescale;
    logic [spwm_pkg::COUNT_W-1:0] n_prescale;
    logic [spwm_pkg::COUNT_W-1:0] r_period;
    logic [spwm_pkg::COUNT_W-1:0] n_period;
    logic                         n_wrap;

    always_comb begin
        n_prescale = r_prescale;
        n_period   = r_period;
        n_wrap     = 1'b0;
        if (i_tick) begin
            if (r_prescale >= i_prescale_div) begin
                n_prescale = '0;
                if (r_period >= i_period_top) begin
                    n_period = '0;
                    n_wrap   = 1'b1;
                end else begin
                    n_period = r_period + spwm_pkg::COUNT_W'(1);
                end
            end else begin
                n_prescale = r_prescale + spwm_pkg::COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale <= '0;
            r_period   <= '0;
        end else begin
            r_prescale <= n_prescale;
            r_period   <= n_period;
        end
    end

    assign o_step.next_count = n_period;
    assign o_step.wrap       = n_wrap;

endmodule

### hw/rtl/spwm_checker.sv
// port-level checks of the servo pwm generator, bound to the top level
`timescale 1ns / 1ps

module spwm_checker #(
    parameter int CHANNELS = spwm_pkg::CHANNELS_DEF
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [spwm_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    localparam logic [spwm_pkg::PWM_W-1:0] PWM_MASK =
        (CHANNELS >= spwm_pkg::PWM_W) ? {spwm_pkg::PWM_W{1'b1}}
                                      : spwm_pkg::PWM_W'((1 << CHANNELS) - 1);

    // a tick never refuses, a set request never wraps
    a_wrap_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[6] && m_axis_tdata[7]))
        else $error("result shows both wrap and refused");

    // levels only on channels that exist
    a_pwm_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[5:0] & ~PWM_MASK) == '0))
        else $error("pwm level on a channel that does not exist");

    // a request taken with the output empty shows its result next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!m_axis_tvalid && s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
        else $error("request accepted without a result");

    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (s_axis_tready && !m_axis_tvalid))
        else $error("output stage not empty after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind servo_pwm_generator spwm_checker #(
    .CHANNELS (CHANNELS)
) u_spwm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
